// ===== rtl/core/rigid_transform_2d_apply_core_macros.svh =====
// assertion macros shared by the rigid transform checker
`ifndef RIGID_TRANSFORM_2D_APPLY_CORE_MACROS_SVH
`define RIGID_TRANSFORM_2D_APPLY_CORE_MACROS_SVH

// checked only out of reset
`define RT2_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define RT2_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/rt2_pkg.sv =====
// package for the planar rigid transform core: codes, sizes and the sine table
`default_nettype none

package rt2_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int TRIG_WIDTH       = 18;
    localparam int TRIG_FRAC        = TRIG_WIDTH - 2;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 32;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        MODE_POINT   = 3'd0,
        MODE_VECTOR  = 3'd1,
        MODE_TWIST   = 3'd2,
        MODE_COMPOSE = 3'd3,
        MODE_INVERSE = 3'd4
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_ANGLE = 2'd0,
        CFG_TRANS_X   = 2'd1,
        CFG_TRANS_Y   = 2'd2
    } cfg_reg_t;

    typedef logic [SINE_TABLE_DEPTH:0][TRIG_FRAC:0] sine_rom_t;

    // sin(pi/2 * i / depth) by taylor series in q30, rounded to q1.frac
    function automatic logic [TRIG_FRAC:0] quarter_sine(int unsigned i);
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] t;
        logic [63:0] v;
        x   = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
        sum = x;
        t   = x;
        for (int k = 1; k <= 8; k++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - t;
            end else begin
                sum = sum + t;
            end
        end
        v = (sum + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
        if (v > (64'd1 << TRIG_FRAC)) begin
            v = 64'd1 << TRIG_FRAC;
        end
        return v[TRIG_FRAC:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            rom[i] = quarter_sine(i);
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rigid_transform_2d_apply_core.sv =====
// top level of the planar rigid transform core
//
// usage
//   configuration: cfg_wen / cfg_index / cfg_wdata, one register per write,
//   index 0 rot_angle, 1 trans_x, 2 trans_y; write only while no item is in flight
//   a rot_angle write loads cos and sin from the quarter-wave table on the
//   following cycle; s_tready is held low in that cycle
//   input items: s_tvalid / s_tready, mode on s_tuser, operands on s_tdata
//   result items: m_tvalid / m_tready, one result per input item, in order
//   path: an accepted item passes through the input register, the product
//   register and the result register before m_tvalid rises
//   throughput: one item per cycle while the result side keeps up and no table
//   load is pending, set by the three-stage pipeline with one 32x32 or 18x32
//   multiplier per product in the middle stage
//   stall: each stage holds while the one after it is full and stalled, so
//   empty stages keep taking items while a result waits on m_tready
//   reset: aresetn low clears all stages, the registers to zero, cos to unity
//   and sin to zero; s_tready is low while in reset
`default_nettype none

module rigid_transform_2d_apply_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wen,
    input  wire logic [rt2_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rt2_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // input items
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [111:0]                      s_tdata,  // in_x, in_y, in_angle, in_rate
    input  wire logic [2:0]                        s_tuser,  // mode
    // result items
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [111:0]                           m_tdata,  // out_x, out_y, out_angle, out_rate
    output logic [0:0]                             m_tuser   // saturated
);

    localparam int TW      = rt2_pkg::TRIG_WIDTH;
    localparam int FR      = rt2_pkg::TRIG_FRAC;
    localparam int IW      = rt2_pkg::SINE_IDX_W;
    localparam int PROD_W  = TW + 32;
    localparam int TWIST_W = 64;
    localparam int ACC_W   = 66;

    localparam rt2_pkg::sine_rom_t SINE_ROM = rt2_pkg::build_sine_rom();

    localparam logic signed [ACC_W-1:0] ACC_ONE   = {{(ACC_W-1){1'b0}}, 1'b1};
    localparam logic signed [ACC_W-1:0] TRIG_HALF = ACC_ONE <<< (FR - 1);
    localparam logic signed [ACC_W-1:0] Q16_HALF  = ACC_ONE <<< 15;
    localparam logic signed [ACC_W-1:0] MAX32     = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] MIN32     = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

    // ------------------------------------------------------------------
    // configuration registers and trig load
    // ------------------------------------------------------------------
    logic [15:0]        rot_angle_reg;
    logic signed [31:0] trans_x_reg;
    logic signed [31:0] trans_y_reg;
    logic signed [TW-1:0] cos_reg;
    logic signed [TW-1:0] sin_reg;
    logic               trig_pend_reg;
    logic [FR:0]        trig_lo_reg;
    logic [FR:0]        trig_hi_reg;
    logic [1:0]         trig_quad_reg;

    logic [IW+13:0]     idx_prod;
    logic [IW-1:0]      trig_idx_next;
    logic [IW-1:0]      trig_hi_idx;
    logic signed [TW-1:0] lo_val;
    logic signed [TW-1:0] hi_val;
    logic signed [TW-1:0] cos_next;
    logic signed [TW-1:0] sin_next;

    // table index of the written angle within its quadrant
    always_comb begin
        idx_prod      = {{IW{1'b0}}, cfg_wdata[13:0]}
                        * (IW + 14)'(rt2_pkg::SINE_TABLE_DEPTH);
        trig_idx_next = idx_prod[IW+13:14];
        trig_hi_idx   = IW'(rt2_pkg::SINE_TABLE_DEPTH) - trig_idx_next;
        lo_val        = {1'b0, trig_lo_reg};
        hi_val        = {1'b0, trig_hi_reg};
        case (trig_quad_reg)
            2'd0: begin
                sin_next = lo_val;
                cos_next = hi_val;
            end
            2'd1: begin
                sin_next = hi_val;
                cos_next = -lo_val;
            end
            2'd2: begin
                sin_next = -lo_val;
                cos_next = -hi_val;
            end
            default: begin
                sin_next = -hi_val;
                cos_next = lo_val;
            end
        endcase
    end

    // registered table read at the angle write
    always_ff @(posedge aclk) begin
        if (cfg_wen && cfg_index == rt2_pkg::CFG_ROT_ANGLE) begin
            trig_lo_reg <= SINE_ROM[trig_idx_next];
            trig_hi_reg <= SINE_ROM[trig_hi_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_angle_reg <= '0;
            trans_x_reg   <= '0;
            trans_y_reg   <= '0;
            cos_reg       <= TW'(1) <<< FR;
            sin_reg       <= '0;
            trig_pend_reg <= 1'b0;
            trig_quad_reg <= '0;
        end else begin
            // the registered table read lands in cos and sin while the load is pending
            if (trig_pend_reg) begin
                cos_reg       <= cos_next;
                sin_reg       <= sin_next;
                trig_pend_reg <= 1'b0;
            end
            if (cfg_wen) begin
                unique case (cfg_index)
                    rt2_pkg::CFG_ROT_ANGLE: begin
                        rot_angle_reg <= cfg_wdata[15:0];
                        trig_quad_reg <= cfg_wdata[15:14];
                        trig_pend_reg <= 1'b1;
                    end
                    rt2_pkg::CFG_TRANS_X: trans_x_reg <= cfg_wdata;
                    rt2_pkg::CFG_TRANS_Y: trans_y_reg <= cfg_wdata;
                    default: ;  // unused index, write is dropped
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline flow: each stage moves when the next has room
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_en;
    logic s2_en;
    logic s1_en;

    assign out_en   = !out_valid_reg || m_tready;
    assign s2_en    = !s2_valid_reg || out_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign s_tready = aresetn && s1_en && !trig_pend_reg;

    // ------------------------------------------------------------------
    // stage 1: input register
    // ------------------------------------------------------------------
    logic [2:0]         s1_mode_reg;
    logic signed [31:0] s1_x_reg;
    logic signed [31:0] s1_y_reg;
    logic [15:0]        s1_angle_reg;
    logic signed [31:0] s1_rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_en) begin
            s1_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_mode_reg  <= s_tuser;
            s1_x_reg     <= s_tdata[31:0];
            s1_y_reg     <= s_tdata[63:32];
            s1_angle_reg <= s_tdata[79:64];
            s1_rate_reg  <= s_tdata[111:80];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: products, angle and rate
    // ------------------------------------------------------------------
    logic signed [31:0]      op_a;
    logic signed [31:0]      op_b;
    logic signed [PROD_W-1:0] p1_next, p2_next, p3_next, p4_next;
    logic signed [TWIST_W-1:0] ptx_next, pty_next;
    logic [15:0]             s2_angle_next;
    logic signed [31:0]      s2_rate_next;

    logic [2:0]              s2_mode_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [TWIST_W-1:0] ptx_reg, pty_reg;
    logic [15:0]             s2_angle_reg;
    logic signed [31:0]      s2_rate_reg;

    always_comb begin
        // inverse mode rotates the translation itself
        if (s1_mode_reg == rt2_pkg::MODE_INVERSE) begin
            op_a = trans_x_reg;
            op_b = trans_y_reg;
        end else begin
            op_a = s1_x_reg;
            op_b = s1_y_reg;
        end
        p1_next  = cos_reg * op_a;
        p2_next  = sin_reg * op_b;
        p3_next  = sin_reg * op_a;
        p4_next  = cos_reg * op_b;
        // adjoint cross terms for twist mode
        ptx_next = trans_y_reg * s1_rate_reg;
        pty_next = trans_x_reg * s1_rate_reg;

        case (s1_mode_reg)
            rt2_pkg::MODE_COMPOSE: s2_angle_next = rot_angle_reg + s1_angle_reg;
            rt2_pkg::MODE_INVERSE: s2_angle_next = 16'd0 - rot_angle_reg;
            default:               s2_angle_next = 16'd0;
        endcase
        s2_rate_next = (s1_mode_reg == rt2_pkg::MODE_TWIST) ? s1_rate_reg : 32'sd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_en) begin
            s2_mode_reg  <= s1_mode_reg;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            p3_reg       <= p3_next;
            p4_reg       <= p4_next;
            ptx_reg      <= ptx_next;
            pty_reg      <= pty_next;
            s2_angle_reg <= s2_angle_next;
            s2_rate_reg  <= s2_rate_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: sums, rounding, offset and saturation
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] e1, e2, e3, e4;
    logic signed [ACC_W-1:0] rot_x_sum, rot_y_sum;
    logic signed [ACC_W-1:0] rot_x, rot_y;
    logic signed [ACC_W-1:0] tw_x, tw_y;
    logic signed [ACC_W-1:0] off_x, off_y;
    logic signed [ACC_W-1:0] sum_x, sum_y;
    logic signed [31:0]      res_x_next, res_y_next;
    logic                    sat_next;
    logic [15:0]             res_angle_next;
    logic signed [31:0]      res_rate_next;
    logic                    known_mode;

    always_comb begin
        e1 = ACC_W'(p1_reg);
        e2 = ACC_W'(p2_reg);
        e3 = ACC_W'(p3_reg);
        e4 = ACC_W'(p4_reg);
        known_mode = 1'b1;
        if (s2_mode_reg == rt2_pkg::MODE_INVERSE) begin
            rot_x_sum = -(e1 + e2);
            rot_y_sum = e3 - e4;
        end else begin
            rot_x_sum = e1 - e2;
            rot_y_sum = e3 + e4;
        end
        // round half up to q16.16: add half an lsb, then floor shift
        rot_x = (rot_x_sum + TRIG_HALF) >>> FR;
        rot_y = (rot_y_sum + TRIG_HALF) >>> FR;
        tw_x  = (ACC_W'(ptx_reg) + Q16_HALF) >>> 16;
        tw_y  = (-ACC_W'(pty_reg) + Q16_HALF) >>> 16;

        case (s2_mode_reg) inside
            rt2_pkg::MODE_POINT, rt2_pkg::MODE_COMPOSE: begin
                off_x = ACC_W'(trans_x_reg);
                off_y = ACC_W'(trans_y_reg);
            end
            rt2_pkg::MODE_TWIST: begin
                off_x = tw_x;
                off_y = tw_y;
            end
            rt2_pkg::MODE_VECTOR, rt2_pkg::MODE_INVERSE: begin
                off_x = '0;
                off_y = '0;
            end
            default: begin
                // undefined mode: all-zero result
                off_x = '0;
                off_y = '0;
                known_mode = 1'b0;
            end
        endcase

        sum_x = known_mode ? (rot_x + off_x) : '0;
        sum_y = known_mode ? (rot_y + off_y) : '0;

        sat_next = 1'b0;
        if (sum_x > MAX32) begin
            res_x_next = 32'sh7fffffff;
            sat_next   = 1'b1;
        end else if (sum_x < MIN32) begin
            res_x_next = 32'sh80000000;
            sat_next   = 1'b1;
        end else begin
            res_x_next = sum_x[31:0];
        end
        if (sum_y > MAX32) begin
            res_y_next = 32'sh7fffffff;
            sat_next   = 1'b1;
        end else if (sum_y < MIN32) begin
            res_y_next = 32'sh80000000;
            sat_next   = 1'b1;
        end else begin
            res_y_next = sum_y[31:0];
        end
        res_angle_next = s2_angle_reg;
        res_rate_next  = s2_rate_reg;
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [111:0] out_tdata_reg;
    logic [0:0]   out_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            out_tdata_reg <= {res_rate_next, res_angle_next, res_y_next, res_x_next};
            out_tuser_reg <= sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tdata_reg;
    assign m_tuser  = out_tuser_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rt2_checker.sv =====
// port-level checker for the rigid transform core, bound to the top level
`default_nettype none
`include "rigid_transform_2d_apply_core_macros.svh"

module rt2_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           cfg_wen,
    input wire logic [rt2_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [rt2_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [111:0]                   s_tdata,
    input wire logic [2:0]                     s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [111:0]                   m_tdata,
    input wire logic [0:0]                     m_tuser
);

    // a stalled result holds its payload
    `RT2_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // reset empties the pipeline
    `RT2_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid right after reset")

    // an angle write blocks input for the table load
    `RT2_ASSERT(a_trig_block, cfg_wen && cfg_index == rt2_pkg::CFG_ROT_ANGLE |=> !s_tready, "item taken during trig load")

    // the saturation flag only comes with a clipped component
    `RT2_ASSERT(a_sat_clip, m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 || m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000, "saturated flag without clipped value")

endmodule

bind rigid_transform_2d_apply_core rt2_checker u_rt2_checker (.*);

`default_nettype wire

// ===== sim/rigid_transform_2d_apply_core_chk.sv =====
// checker for the planar rigid transform core: predicts each result item and compares it
module rigid_transform_2d_apply_core_chk (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wen,
    input  wire logic [rt2_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rt2_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [111:0]                   s_tdata,  // in_x, in_y, in_angle, in_rate
    input  wire logic [2:0]                     s_tuser,  // mode
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [111:0]                   m_tdata,  // out_x, out_y, out_angle, out_rate
    input  wire logic [0:0]                     m_tuser,  // saturated
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [15:0] angle;
        logic [31:0] rate;
        logic        sat;
    } pose_result_t;

    // local copy of the configured pose and its latched trig values
    logic [15:0] rot_angle_q;
    longint      shift_x;
    longint      shift_y;
    longint      cos_q;
    longint      sin_q;

    pose_result_t transformed_q[$];

    // quarter-wave sine in q1.frac, taylor series evaluated in q30
    function automatic longint table_sine(longint unsigned idx);
        longint unsigned arg;
        longint unsigned acc;
        longint unsigned term;
        arg  = (rt2_pkg::HALF_PI_Q30 * idx) / rt2_pkg::SINE_TABLE_DEPTH;
        acc  = arg;
        term = arg;
        for (int k = 1; k <= 8; k++) begin
            term = (((term * arg) >> 30) * arg) >> 30;
            term = term / ((2 * k) * (2 * k + 1));
            acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
        acc = (acc + (64'd1 << (29 - rt2_pkg::TRIG_FRAC))) >> (30 - rt2_pkg::TRIG_FRAC);
        if (acc > (64'd1 << rt2_pkg::TRIG_FRAC)) begin
            acc = 64'd1 << rt2_pkg::TRIG_FRAC;
        end
        return longint'(acc);
    endfunction

    function automatic void load_trig(logic [15:0] ang);
        longint unsigned slot;
        longint          near_v;
        longint          far_v;
        slot   = (longint'(ang[13:0]) * rt2_pkg::SINE_TABLE_DEPTH) >> 14;
        near_v = table_sine(slot);
        far_v  = table_sine(rt2_pkg::SINE_TABLE_DEPTH - slot);
        case (ang[15:14])
            2'd0: begin
                sin_q = near_v;
                cos_q = far_v;
            end
            2'd1: begin
                sin_q = far_v;
                cos_q = -near_v;
            end
            2'd2: begin
                sin_q = -near_v;
                cos_q = -far_v;
            end
            default: begin
                sin_q = -far_v;
                cos_q = near_v;
            end
        endcase
    endfunction

    // add half an lsb, then floor shift
    function automatic longint round_down(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic logic [31:0] clamp_q16(longint v);
        if (v > Q_MAX) begin
            return 32'h7fff_ffff;
        end
        if (v < Q_MIN) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic pose_result_t transform_item(logic [2:0] mode, logic [31:0] x_in,
                                                    logic [31:0] y_in, logic [15:0] ang_in,
                                                    logic [31:0] rate_in);
        longint       ix;
        longint       iy;
        longint       ir;
        longint       rx;
        longint       ry;
        pose_result_t r;
        ix = signed'(x_in);
        iy = signed'(y_in);
        ir = signed'(rate_in);
        rx = 0;
        ry = 0;
        r  = '0;
        case (mode)
            rt2_pkg::MODE_POINT, rt2_pkg::MODE_VECTOR, rt2_pkg::MODE_COMPOSE: begin
                rx = round_down(cos_q * ix - sin_q * iy, rt2_pkg::TRIG_FRAC);
                ry = round_down(sin_q * ix + cos_q * iy, rt2_pkg::TRIG_FRAC);
                if (mode != rt2_pkg::MODE_VECTOR) begin
                    rx += shift_x;
                    ry += shift_y;
                end
                if (mode == rt2_pkg::MODE_COMPOSE) begin
                    r.angle = rot_angle_q + ang_in;
                end
            end
            rt2_pkg::MODE_TWIST: begin
                rx = round_down(shift_y * ir, 16)
                   + round_down(cos_q * ix - sin_q * iy, rt2_pkg::TRIG_FRAC);
                ry = round_down(-(shift_x * ir), 16)
                   + round_down(sin_q * ix + cos_q * iy, rt2_pkg::TRIG_FRAC);
                r.rate = rate_in;
            end
            rt2_pkg::MODE_INVERSE: begin
                rx = round_down(-(cos_q * shift_x + sin_q * shift_y), rt2_pkg::TRIG_FRAC);
                ry = round_down(sin_q * shift_x - cos_q * shift_y, rt2_pkg::TRIG_FRAC);
                r.angle = -rot_angle_q;
            end
            default: begin
                // spare codes give an all-zero result
            end
        endcase
        r.sat = (rx > Q_MAX) || (rx < Q_MIN) || (ry > Q_MAX) || (ry < Q_MIN);
        r.x   = clamp_q16(rx);
        r.y   = clamp_q16(ry);
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %h got %h", $time, what, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        pose_result_t want;
        pose_result_t got;
        if (!aresetn) begin
            rot_angle_q = '0;
            shift_x     = 0;
            shift_y     = 0;
            cos_q       = longint'(1) << rt2_pkg::TRIG_FRAC;
            sin_q       = 0;
            transformed_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[63:32], m_tdata[79:64], m_tdata[111:80],
                       m_tuser[0]};
                if (transformed_q.size() == 0) begin
                    $display("%0t: result item with none expected, got %h", $time, got);
                    mismatches++;
                end else begin
                    want = transformed_q.pop_front();
                    check_field("out_x", want.x, got.x);
                    check_field("out_y", want.y, got.y);
                    check_field("out_angle", want.angle, got.angle);
                    check_field("out_rate", want.rate, got.rate);
                    check_field("saturated", want.sat, got.sat);
                end
            end
            if (s_tvalid && s_tready) begin
                transformed_q.push_back(transform_item(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                                       s_tdata[79:64], s_tdata[111:80]));
            end
            if (cfg_wen) begin
                case (cfg_index)
                    rt2_pkg::CFG_ROT_ANGLE: begin
                        rot_angle_q = cfg_wdata[15:0];
                        load_trig(rot_angle_q);
                    end
                    rt2_pkg::CFG_TRANS_X: shift_x = signed'(cfg_wdata);
                    rt2_pkg::CFG_TRANS_Y: shift_y = signed'(cfg_wdata);
                    default: begin
                    end
                endcase
            end
        end
        outstanding <= transformed_q.size();
    end

endmodule

// ===== sim/rigid_transform_2d_apply_core_tb.sv =====
// testbench top for the planar rigid transform core: stimulus, pacing and verdict
module rigid_transform_2d_apply_core_tb;

    localparam int RUN_LIMIT       = 250000;  // several times the slowest legal run
    localparam int HOLD_CYCLES     = 300;     // long receiver hold-off
    localparam int TAIL_CYCLES     = 10;      // idle tail after draining
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 100;

    // codes past the last defined mode
    localparam logic [2:0] MODE_SPARE_LO = rt2_pkg::MODE_INVERSE + 3'd1;
    localparam logic [2:0] MODE_SPARE_HI = '1;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_wen   = 1'b0;
    logic [rt2_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rt2_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic         s_tvalid  = 1'b0;
    logic [111:0] s_tdata   = '0;  // in_x, in_y, in_angle, in_rate
    logic [2:0]   s_tuser   = '0;  // mode
    logic         m_tready  = 1'b0;
    wire logic          s_tready;
    wire logic          m_tvalid;
    wire logic [111:0]  m_tdata;   // out_x, out_y, out_angle, out_rate
    wire logic [0:0]    m_tuser;   // saturated

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    // pacing controls shared by the sender and the receiver
    bit quiet_phase  = 1'b0;  // no gaps on either side
    bit hold_off_req = 1'b0;  // receiver parks for HOLD_CYCLES

    rigid_transform_2d_apply_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    rigid_transform_2d_apply_core_chk chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // run limit
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[rigid_transform_2d_apply_core] ERROR");
        $finish;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_cycles();
        int roll;
        if (quiet_phase) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // q16.16 operand: extremes, small magnitudes near zero, or any pattern
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3, 4, 5: return $urandom_range(0, 32'h001f_ffff) - 32'h0010_0000;
            6: return $urandom_range(0, 255) - 32'd128;
            default: return $urandom();
        endcase
    endfunction

    // binary angle: wrap points, quarter turns, or any value
    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return {2'($urandom_range(0, 3)), 14'h0000};
            default: return 16'($urandom_range(0, 16'hffff));
        endcase
    endfunction

    // defined modes mostly, spare codes now and then
    function automatic logic [2:0] pick_mode();
        if ($urandom_range(0, 99) < 8) begin
            return 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
        end
        return 3'($urandom_range(rt2_pkg::MODE_POINT, rt2_pkg::MODE_INVERSE));
    endfunction

    // offer one item after an optional gap, return at its handshake edge
    task automatic push_item(logic [2:0] mode, logic [31:0] x_v, logic [31:0] y_v,
                             logic [15:0] a_v, logic [31:0] r_v);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {r_v, a_v, y_v, x_v};
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering and wait for every expected result item
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // write all three pose registers on consecutive edges, only while drained
    task automatic load_pose(logic [15:0] ang, logic [31:0] tx, logic [31:0] ty);
        cfg_wen   <= 1'b1;
        cfg_index <= rt2_pkg::CFG_ROT_ANGLE;
        cfg_wdata <= {{16{ang[15]}}, ang};
        @(posedge aclk);
        cfg_index <= rt2_pkg::CFG_TRANS_X;
        cfg_wdata <= tx;
        @(posedge aclk);
        cfg_index <= rt2_pkg::CFG_TRANS_Y;
        cfg_wdata <= ty;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int pause;
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                pause = idle_cycles();
                if (pause > 0) begin
                    m_tready <= 1'b0;
                    repeat (pause) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int m;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity pose out of reset: extremes pass straight through
        push_item(rt2_pkg::MODE_POINT, 32'h7fff_ffff, 32'h8000_0000, 16'h0000, 32'h0000_0000);
        push_item(rt2_pkg::MODE_VECTOR, 32'h8000_0000, 32'h7fff_ffff, 16'hffff, 32'hffff_ffff);
        push_item(rt2_pkg::MODE_TWIST, 32'h0000_0001, 32'hffff_ffff, 16'h0000, 32'h7fff_ffff);
        push_item(rt2_pkg::MODE_COMPOSE, 32'h0005_0000, 32'h0005_0000, 16'h7fff, 32'h0000_0000);
        push_item(rt2_pkg::MODE_INVERSE, 32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000);

        // half turn with extreme translation: saturation and angle wrap
        wait_drained();
        load_pose(16'h8000, 32'h7fff_ffff, 32'h8000_0000);
        push_item(rt2_pkg::MODE_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 16'h0000, 32'h0000_0000);
        push_item(rt2_pkg::MODE_POINT, 32'h8000_0000, 32'h8000_0000, 16'h0000, 32'h0000_0000);
        push_item(rt2_pkg::MODE_VECTOR, 32'h7fff_ffff, 32'h8000_0000, 16'h0000, 32'h0000_0000);
        push_item(rt2_pkg::MODE_TWIST, 32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h8000_0000);
        push_item(rt2_pkg::MODE_TWIST, 32'h0001_0000, 32'hffff_0000, 16'h0000, 32'h7fff_ffff);
        push_item(rt2_pkg::MODE_COMPOSE, 32'h0000_0000, 32'h0000_0000, 16'h8000, 32'h0000_0000);
        push_item(rt2_pkg::MODE_COMPOSE, 32'h0001_0000, 32'h0001_0000, 16'h7fff, 32'h0000_0000);
        // inverse of minus half turn stays at minus half turn
        push_item(rt2_pkg::MODE_INVERSE, 32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000);
        // spare mode codes with every operand bit set
        for (m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) begin
            push_item(3'(m), 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
        end

        // quarter turn with a modest offset
        wait_drained();
        load_pose(16'h4000, 32'h0003_8000, 32'hfffe_8000);
        push_item(rt2_pkg::MODE_POINT, 32'h0002_0000, 32'h0001_0000, 16'h0000, 32'h0000_0000);
        push_item(rt2_pkg::MODE_TWIST, 32'h0001_0000, 32'h0000_8000, 16'h0000, 32'h0000_c000);
        push_item(rt2_pkg::MODE_INVERSE, 32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000);

        // random phases, each under its own pose
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: load_pose(16'h7fff, 32'h7fff_ffff, 32'h7fff_ffff);
                1: load_pose(16'h8000, 32'h8000_0000, 32'h8000_0000);
                2: load_pose(16'h0000, 32'h0000_0000, 32'h0000_0000);
                default: load_pose(pick_angle(), pick_q16(), pick_q16());
            endcase
            quiet_phase = (p % 4 == 2);
            // the block fills up and holds its input while the receiver is parked
            if (p == 3) begin
                hold_off_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                push_item(pick_mode(), pick_q16(), pick_q16(), pick_angle(), pick_q16());
            end
        end
        quiet_phase = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[rigid_transform_2d_apply_core] OK");
        end else begin
            $display("[rigid_transform_2d_apply_core] ERROR");
        end
        $finish;
    end

endmodule
